// ----- src/gcbt_pkg.sv -----
// Package for the grid cell binning table: sizes, operation and status codes.
// No dependencies; used by grid_cell_binning_table_core.
`default_nettype none
package gcbt_pkg;
  localparam int GridSide     = 16;
  localparam int SlotsPerCell = 16;
  localparam int MaxAgents    = 256;
  localparam int NumCells     = GridSide * GridSide;
  localparam int CellW        = $clog2(NumCells);
  localparam int SlotW        = $clog2(SlotsPerCell);
  localparam int AgentW       = $clog2(MaxAgents);
  localparam int FillW        = SlotW + 1;
  localparam int GridW        = $clog2(GridSide);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_PLACED  = 3'd2;
  localparam logic [2:0] ST_UNPLACE = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CSIZE  = 3'd2;
  localparam logic [2:0] REG_ACROSS = 3'd3;
  localparam logic [2:0] REG_DOWN   = 3'd4;
endpackage
`default_nettype wire

// ----- src/grid_cell_binning_table_core.sv -----
// Grid cell binning table: top level with the APB register file, the shared
// restoring divider, the table memories and the control sequencer. Uses gcbt_pkg.
//
// Channel   Signals                                   Transfer
// command   start, busy, operation, agent_id, pos_*   start && !busy
// result    done, status, cell_index, slot, moved_*   done (one cycle)
// config    psel, penable, pwrite, paddr, pwdata      psel&&penable&&pwrite
//
// An insert of an unplaced agent runs two 17-bit restoring divisions in a single
// shared divider, then a read and a write-back of the fill memory. An insert of a
// placed agent reads its home cell and slot; a remove reads them, then the fill
// memory and the last slot of the cell; a clear makes one pass over the fill memory.
// After reset a clearing pass over the fill memory runs with busy high.
// Results cannot be stalled; one item is worked on at a time.
`default_nettype none
module grid_cell_binning_table_core import gcbt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  agent_id,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_z,
  output logic             done,
  output logic [2:0]       status,
  output logic [7:0]       cell_index,
  output logic [3:0]       slot,
  output logic [7:0]       moved_agent,
  output logic             moved_valid,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DIVX, S_DIVZ, S_INS_RD, S_INS_CHK,
    S_HOME_RD, S_HOME_WAIT, S_REM_FILL, S_REM_LAST, S_REM_MOVE,
    S_CLR, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] world_width, world_height, cell_size;
  logic [4:0]  cells_across, cells_down;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_width  <= 16'd160;
      world_height <= 16'd160;
      cell_size    <= 16'd10;
      cells_across <= 5'd16;
      cells_down   <= 5'd16;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_WIDTH:  world_width  <= pwdata[15:0];
        REG_HEIGHT: world_height <= pwdata[15:0];
        REG_CSIZE:  cell_size    <= pwdata[15:0];
        REG_ACROSS: cells_across <= pwdata[4:0];
        REG_DOWN:   cells_down   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WIDTH:  prdata = {16'd0, world_width};
      REG_HEIGHT: prdata = {16'd0, world_height};
      REG_CSIZE:  prdata = {16'd0, cell_size};
      REG_ACROSS: prdata = {27'd0, cells_across};
      REG_DOWN:   prdata = {27'd0, cells_down};
      default:    prdata = 32'd0;
    endcase
  end

  // Clamped grid dimensions and the doubled divisor.
  logic [4:0]  across, down;
  logic [16:0] divisor;
  always_comb begin
    across = (cells_across == 5'd0) ? 5'd1 :
             (cells_across > 5'(GridSide)) ? 5'(GridSide) : cells_across;
    down   = (cells_down == 5'd0) ? 5'd1 :
             (cells_down > 5'(GridSide)) ? 5'(GridSide) : cells_down;
    divisor = {((cell_size == 16'd0) ? 16'd1 : cell_size), 1'b0};
  end

  // Memories: members, fill count, home cell and slot. Placed bits are flops.
  logic [AgentW-1:0] members_mem [NumCells*SlotsPerCell];
  logic [FillW-1:0]  fill_mem    [NumCells];
  logic [CellW-1:0]  hcell_mem   [MaxAgents];
  logic [SlotW-1:0]  hslot_mem   [MaxAgents];
  logic [MaxAgents-1:0] placed;

  logic [CellW+SlotW-1:0] mem_addr;
  logic                   mem_we;
  logic [AgentW-1:0]      mem_wd, mem_rd;
  logic [CellW-1:0]       fill_addr;
  logic                   fill_we;
  logic [FillW-1:0]       fill_wd, fill_rd;
  logic [AgentW-1:0]      home_addr;
  logic                   hcell_we, hslot_we;
  logic [CellW-1:0]       hcell_wd, hcell_rd;
  logic [SlotW-1:0]       hslot_wd, hslot_rd;

  always_ff @(posedge clk) begin
    if (mem_we) members_mem[mem_addr] <= mem_wd;
    mem_rd <= members_mem[mem_addr];
  end
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_addr] <= fill_wd;
    fill_rd <= fill_mem[fill_addr];
  end
  always_ff @(posedge clk) begin
    if (hcell_we) hcell_mem[home_addr] <= hcell_wd;
    hcell_rd <= hcell_mem[home_addr];
  end
  always_ff @(posedge clk) begin
    if (hslot_we) hslot_mem[home_addr] <= hslot_wd;
    hslot_rd <= hslot_mem[home_addr];
  end

  // Working registers.
  logic [AgentW-1:0] aid;
  logic signed [15:0] pz;
  logic [16:0] rem, quo;
  logic [4:0]  step;
  logic        neg;
  logic [GridW-1:0] cx;
  logic [CellW-1:0] cur_cell, clr_cnt;
  logic [SlotW-1:0] hslot;
  logic [FillW-1:0] fill;

  // Doubled, offset coordinate: s = 2*pos + extent, 18 bits signed.
  function automatic logic signed [17:0] offset_pos(logic signed [15:0] p,
                                                    logic [15:0] ext);
    offset_pos = 18'(signed'({p, 1'b0})) + signed'({2'b00, ext});
  endfunction

  // Clamp a quotient to the range 0 to count-1; a negative value gives 0.
  function automatic logic [GridW-1:0] clamp_q(logic [16:0] q, logic nq,
                                               logic [4:0] cnt);
    logic [4:0] lim;
    lim = cnt - 5'd1;
    if (nq) clamp_q = '0;
    else if (q >= {12'd0, cnt}) clamp_q = lim[GridW-1:0];
    else clamp_q = q[GridW-1:0];
  endfunction

  // One restoring step of the shared divider.
  logic [17:0] trial;
  assign trial = {rem, quo[16]} - {1'b0, divisor};

  logic signed [17:0] sz_off;
  assign sz_off = offset_pos(pz, world_height);

  // Index of the last occupied slot of the cell being left, from the fill read.
  logic [FillW-1:0] rem_last;
  assign rem_last = (fill_rd == '0) ? '0 : fill_rd - FillW'(1);

  // Memory port control.
  always_comb begin
    mem_addr  = {cur_cell, hslot};
    mem_we    = 1'b0;
    mem_wd    = aid;
    fill_addr = cur_cell;
    fill_we   = 1'b0;
    fill_wd   = '0;
    home_addr = aid;
    hcell_we  = 1'b0;
    hslot_we  = 1'b0;
    hcell_wd  = cur_cell;
    hslot_wd  = hslot;
    case (state)
      S_INIT, S_CLR: begin
        fill_addr = clr_cnt;
        fill_we   = 1'b1;
      end
      S_INS_CHK: begin
        if (fill_rd < FillW'(SlotsPerCell)) begin
          mem_addr = {cur_cell, fill_rd[SlotW-1:0]};
          mem_we   = 1'b1;
          fill_we  = 1'b1;
          fill_wd  = fill_rd + FillW'(1);
          hcell_we = 1'b1;
          hslot_we = 1'b1;
          hslot_wd = fill_rd[SlotW-1:0];
        end
      end
      S_REM_FILL: begin
        fill_addr = hcell_rd;
      end
      S_REM_LAST: begin
        mem_addr = {cur_cell, rem_last[SlotW-1:0]};
        fill_we  = 1'b1;
        fill_wd  = rem_last;
      end
      S_REM_MOVE: begin
        mem_we    = 1'b1;
        mem_wd    = mem_rd;
        home_addr = mem_rd;
        hslot_we  = (fill[SlotW-1:0] != hslot);
      end
      default: ;
    endcase
  end

  // Remember whether the item in flight is an insert.
  logic operation_q_insert;
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) operation_q_insert <= (operation == OP_INSERT);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      clr_cnt <= '0;
      placed  <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT, S_CLR: begin
          placed  <= '0;
          clr_cnt <= clr_cnt + CellW'(1);
          if (clr_cnt == CellW'(NumCells - 1)) begin
            state <= (state == S_CLR) ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            aid         <= agent_id[AgentW-1:0];
            pz          <= pos_z;
            status      <= ST_OK;
            cell_index  <= '0;
            slot        <= '0;
            moved_agent <= '0;
            moved_valid <= 1'b0;
            step        <= '0;
            case (operation)
              OP_INSERT: begin
                if (placed[agent_id[AgentW-1:0]]) state <= S_HOME_RD;
                else begin
                  neg   <= offset_pos(pos_x, world_width) < 0;
                  quo   <= 17'(offset_pos(pos_x, world_width));
                  rem   <= '0;
                  state <= S_DIVX;
                end
              end
              OP_REMOVE: begin
                if (!placed[agent_id[AgentW-1:0]]) begin
                  status <= ST_UNPLACE;
                  state  <= S_DONE;
                end else state <= S_HOME_RD;
              end
              OP_CLEAR: begin
                status  <= ST_CLEARED;
                clr_cnt <= '0;
                state   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_DIVX, S_DIVZ: begin
          rem  <= trial[17] ? {rem[15:0], quo[16]} : trial[16:0];
          quo  <= {quo[15:0], ~trial[17]};
          step <= step + 5'd1;
          if (step == 5'd16) begin
            if (state == S_DIVX) begin
              cx    <= clamp_q({quo[15:0], ~trial[17]}, neg, across);
              neg   <= sz_off < 0;
              quo   <= 17'(sz_off);
              rem   <= '0;
              step  <= '0;
              state <= S_DIVZ;
            end else begin
              cur_cell <= CellW'(clamp_q({quo[15:0], ~trial[17]}, neg, down)
                          * across + {3'd0, cx});
              state    <= S_INS_RD;
            end
          end
        end
        S_INS_RD: state <= S_INS_CHK;
        S_INS_CHK: begin
          cell_index <= 8'(cur_cell);
          if (fill_rd < FillW'(SlotsPerCell)) begin
            slot        <= 4'(fill_rd[SlotW-1:0]);
            placed[aid] <= 1'b1;
          end else status <= ST_FULL;
          state <= S_DONE;
        end
        S_HOME_RD: state <= S_HOME_WAIT;
        S_HOME_WAIT: begin
          cur_cell <= hcell_rd;
          hslot    <= hslot_rd;
          if (placed[aid] && status == ST_OK && operation_q_insert) begin
            status     <= ST_PLACED;
            cell_index <= 8'(hcell_rd);
            slot       <= 4'(hslot_rd);
            state      <= S_DONE;
          end else state <= S_REM_FILL;
        end
        S_REM_FILL: state <= S_REM_LAST;
        default: ;
      endcase
      case (state)
        S_REM_LAST: begin
          fill  <= rem_last;
          state <= S_REM_MOVE;
        end
        S_REM_MOVE: begin
          cell_index  <= 8'(cur_cell);
          slot        <= 4'(hslot);
          placed[aid] <= 1'b0;
          if (fill[SlotW-1:0] != hslot) begin
            moved_agent <= 8'(mem_rd);
            moved_valid <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for grid_cell_binning_table_core: directed table, then
// random insert/remove/clear traffic under several grid settings. Uses gcbt_pkg.
`default_nettype none
module testbench;
  import gcbt_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] cidx;
    logic [3:0] slot;
    logic [7:0] moved;
    logic       mvalid;
  } bin_result_t;

  typedef struct packed {
    logic        on;
    bin_result_t r;
  } typed_bin_t;

  typedef struct {
    bin_result_t predicted;
    typed_bin_t  typed;
  } bin_expect_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  id;
    int          x;
    int          z;
    typed_bin_t  typed;
  } bin_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = OP_INSERT;
  logic [7:0] agent_id = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_z = '0;
  logic done;
  logic [2:0] status;
  logic [7:0] cell_index;
  logic [3:0] slot;
  logic [7:0] moved_agent;
  logic moved_valid;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  typed_bin_t typed_row = '0;
  bin_expect_t pending_bins[$];
  int errors = 0;
  int cycles = 0;
  int sender_idle_pct = 0;

  // Shadow of the grid configuration and the binning tables.
  int grid_w, grid_h, grid_cs, grid_across, grid_down;
  logic [7:0] slot_agent [NumCells][SlotsPerCell];
  int fill_count [NumCells];
  logic [7:0] home_cell [MaxAgents];
  logic [3:0] home_slot [MaxAgents];
  bit placed [MaxAgents];

  grid_cell_binning_table_core u_top (
    .clk, .rst, .start, .busy, .operation, .agent_id, .pos_x, .pos_z,
    .done, .status, .cell_index, .slot, .moved_agent, .moved_valid,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int grid_count(int n);
    if (n == 0) return 1;
    if (n > GridSide) return GridSide;
    return n;
  endfunction

  // Position to grid coordinate along one axis, offset by half the extent.
  function automatic int axis_bin(int pos, int extent, int count);
    int s;
    int cs;
    int q;
    s = 2 * pos + extent;
    cs = (grid_cs == 0) ? 1 : grid_cs;
    if (s < 0) return 0;
    q = s / (2 * cs);
    if (q >= count) q = count - 1;
    return q;
  endfunction

  // Applies one command to the shadow tables; returns 0 when it has no result.
  function automatic bit bin_step(logic [1:0] op, logic [7:0] id, int px, int pz,
                                  output bin_result_t r);
    int across;
    int down;
    int c;
    int s;
    int last;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (placed[id]) begin
          r.status = ST_PLACED;
          r.cidx = home_cell[id];
          r.slot = home_slot[id];
        end else begin
          across = grid_count(grid_across);
          down = grid_count(grid_down);
          c = axis_bin(pz, grid_h, down) * across + axis_bin(px, grid_w, across);
          r.cidx = 8'(c);
          if (fill_count[c] >= SlotsPerCell) begin
            r.status = ST_FULL;
          end else begin
            s = fill_count[c];
            r.status = ST_OK;
            r.slot = 4'(s);
            slot_agent[c][s] = id;
            fill_count[c] = s + 1;
            home_cell[id] = 8'(c);
            home_slot[id] = 4'(s);
            placed[id] = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (!placed[id]) begin
          r.status = ST_UNPLACE;
        end else begin
          c = home_cell[id];
          s = home_slot[id];
          last = (fill_count[c] == 0) ? 0 : fill_count[c] - 1;
          r.status = ST_OK;
          r.cidx = 8'(c);
          r.slot = 4'(s);
          if (last != s) begin
            r.moved = slot_agent[c][last];
            r.mvalid = 1'b1;
            slot_agent[c][s] = r.moved;
            home_slot[r.moved] = 4'(s);
          end
          fill_count[c] = last;
          placed[id] = 1'b0;
        end
      end
      OP_CLEAR: begin
        foreach (fill_count[i]) fill_count[i] = 0;
        foreach (placed[i]) placed[i] = 1'b0;
        r.status = ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      errors++;
    end
  endtask

  task automatic check_bin(bin_result_t e);
    check_field("status", e.status, status);
    check_field("cell_index", e.cidx, cell_index);
    check_field("slot", e.slot, slot);
    check_field("moved_agent", e.moved, moved_agent);
    check_field("moved_valid", e.mvalid, moved_valid);
  endtask

  // Result check comes first so a result on the edge of a new transfer pairs
  // with the older expectation.
  always @(posedge clk) begin
    bin_expect_t e;
    bin_result_t r;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (pending_bins.size() == 0) begin
          $error("result with no command waiting");
          errors++;
        end else begin
          e = pending_bins.pop_front();
          check_bin(e.predicted);
          if (e.typed.on) check_bin(e.typed.r);
        end
      end
      if (start && !busy) begin
        if (bin_step(operation, agent_id, pos_x, pos_z, r)) begin
          e.predicted = r;
          e.typed = typed_row;
          pending_bins.insert(pending_bins.size(), e);
        end
      end
    end
  end

  // Drives one command and holds it until the block takes the transfer.
  task automatic send_cmd(logic [1:0] op, logic [7:0] id, int x, int z, typed_bin_t t);
    operation <= op;
    agent_id <= id;
    pos_x <= x[15:0];
    pos_z <= z[15:0];
    typed_row <= t;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Waits out every result, then the latency of a command with no result.
  task automatic settle();
    stop_sending();
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  grid_w = value & 16'hFFFF;
      REG_HEIGHT: grid_h = value & 16'hFFFF;
      REG_CSIZE:  grid_cs = value & 16'hFFFF;
      REG_ACROSS: grid_across = value & 5'h1F;
      default:    grid_down = value & 5'h1F;
    endcase
  endtask

  task automatic set_grid(int w, int h, int cs, int across, int down);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_CSIZE, cs);
    reg_write(REG_ACROSS, across);
    reg_write(REG_DOWN, down);
  endtask

  // A coordinate mostly inside the world and a little past its edges.
  function automatic int rand_coord(int extent);
    int lo;
    int v;
    if ($urandom_range(9) == 0) return $signed(16'($urandom));
    lo = -(extent / 2) - 4;
    v = lo + $urandom_range(0, extent + 8);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic logic [7:0] rand_agent(int pool);
    logic [7:0] id;
    int tries;
    if ($urandom_range(9) == 0) return 8'($urandom);
    for (tries = 0; tries < 8; tries++) begin
      id = 8'($urandom_range(0, pool - 1));
      if (placed[id]) return id;
    end
    return id;
  endfunction

  task automatic run_random(int count, int pool);
    int k;
    int pick;
    logic [1:0] op;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) op = OP_INSERT;
      else if (pick < 94) op = OP_REMOVE;
      else if (pick < 97) op = OP_CLEAR;
      else op = OP_UNUSED;
      if (op == OP_INSERT)
        send_cmd(op, 8'($urandom_range(0, pool - 1) | ($urandom_range(19) == 0 ?
                 $urandom : 0)), rand_coord(grid_w), rand_coord(grid_h), '0);
      else
        send_cmd(op, rand_agent(pool), $signed(16'($urandom)), $signed(16'($urandom)), '0);
      if (k == count / 2 && pool == 32) begin
        // Let the pipeline drain completely before carrying on.
        stop_sending();
        while (pending_bins.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    bin_row_t rows[$];
    int n;
    grid_w = 160;
    grid_h = 160;
    grid_cs = 10;
    grid_across = 16;
    grid_down = 16;
    foreach (fill_count[i]) fill_count[i] = 0;
    foreach (placed[i]) placed[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed transfers on the reset grid; typed rows are read off directly.
    rows = '{
      '{OP_INSERT, 8'd0, 0, 0, '{1'b1, '{ST_OK, 8'd136, 4'd0, 8'd0, 1'b0}}},
      '{OP_INSERT, 8'd0, 5, 5, '{1'b1, '{ST_PLACED, 8'd136, 4'd0, 8'd0, 1'b0}}},
      '{OP_INSERT, 8'd1, -32768, -32768, '{1'b1, '{ST_OK, 8'd0, 4'd0, 8'd0, 1'b0}}},
      '{OP_INSERT, 8'd255, 32767, 32767, '{1'b1, '{ST_OK, 8'd255, 4'd0, 8'd0, 1'b0}}},
      '{OP_REMOVE, 8'd5, 0, 0, '{1'b1, '{ST_UNPLACE, 8'd0, 4'd0, 8'd0, 1'b0}}},
      '{OP_INSERT, 8'd2, 0, 0, '0},
      '{OP_INSERT, 8'd3, 4, 9, '0},
      '{OP_REMOVE, 8'd0, 0, 0, '0},
      '{OP_REMOVE, 8'd3, 0, 0, '0},
      '{OP_REMOVE, 8'd2, 0, 0, '0},
      '{OP_INSERT, 8'd170, -80, 79, '0},
      '{OP_INSERT, 8'd85, 79, -81, '0},
      '{OP_UNUSED, 8'd9, 0, 0, '0},
      '{OP_REMOVE, 8'd255, 0, 0, '{1'b1, '{ST_OK, 8'd255, 4'd0, 8'd0, 1'b0}}},
      '{OP_CLEAR, 8'd0, 0, 0, '{1'b1, '{ST_CLEARED, 8'd0, 4'd0, 8'd0, 1'b0}}},
      '{OP_REMOVE, 8'd1, 0, 0, '{1'b1, '{ST_UNPLACE, 8'd0, 4'd0, 8'd0, 1'b0}}}
    };
    foreach (rows[i]) send_cmd(rows[i].op, rows[i].id, rows[i].x, rows[i].z, rows[i].typed);
    run_random(150, 32);
    settle();

    // Grid settings, extremes first, with the idle patterns taken in turn from three.
    for (n = 0; n < 7; n++) begin
      case (n)
        0: set_grid(65535, 65535, 65535, 16, 16);
        1: set_grid(1, 1, 1, 1, 1);
        2: set_grid(100, 60, 0, 0, 31);
        3: set_grid(40, 40, 3, 31, 5);
        4: set_grid(65535, 1, 4096, 16, 1);
        5: set_grid(160, 160, 10, 16, 16);
        default: set_grid($urandom_range(1, 65535), $urandom_range(1, 65535),
                          $urandom_range(1, 300), $urandom_range(0, 31),
                          $urandom_range(0, 31));
      endcase
      case (n % 3)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 65;
        default: sender_idle_pct = 6;
      endcase
      run_random(160, (n == 5) ? 256 : 32);
      settle();
    end

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- grid_cell_binning_table_core.f -----
src/gcbt_pkg.sv
src/grid_cell_binning_table_core.sv
test/testbench.sv
